/* hw/rtl/gzhp_pkg.sv */
// Package for the gzip member header parser.
// Holds the parse phase and status types, header constants and the section chooser.
// No dependencies.
`default_nettype none

package gzhp_pkg;

	typedef enum logic [3:0] {
		PH_MAGIC0  = 4'd0,
		PH_MAGIC1  = 4'd1,
		PH_METHOD  = 4'd2,
		PH_FLAGS   = 4'd3,
		PH_SKIP    = 4'd4,
		PH_XLEN0   = 4'd5,
		PH_XLEN1   = 4'd6,
		PH_XDATA   = 4'd7,
		PH_NAME    = 4'd8,
		PH_COMMENT = 4'd9,
		PH_HCRC    = 4'd10,
		PH_BODY    = 4'd11,
		PH_ERROR   = 4'd12
	} phase_t;

	typedef enum logic [1:0] {
		ST_PARSING   = 2'd0,
		ST_ACCEPTED  = 2'd1,
		ST_NOT_GZIP  = 2'd2,
		ST_HDR_ERROR = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		SEC_FIXED   = 3'd0,
		SEC_EXTRA   = 3'd1,
		SEC_NAME    = 3'd2,
		SEC_COMMENT = 3'd3,
		SEC_HCRC    = 3'd4
	} section_t;

	localparam logic [7:0] MAGIC0_BYTE   = 8'h1f;
	localparam logic [7:0] MAGIC1_BYTE   = 8'h8b;
	localparam logic [7:0] METHOD_DEFL   = 8'h08;
	localparam logic [7:0] FLG_RESERVED  = 8'he0;
	localparam logic [15:0] FIXED_SKIP   = 16'd6;
	localparam logic [15:0] HCRC_SKIP    = 16'd2;

	// Bits of the stored flags (flags byte bits 1 to 4).
	localparam int unsigned FL_HCRC    = 0;
	localparam int unsigned FL_EXTRA   = 1;
	localparam int unsigned FL_NAME    = 2;
	localparam int unsigned FL_COMMENT = 3;

	typedef struct packed {
		logic          payload_valid;
		logic [7:0]    payload_byte;
		status_t       header_status;
		logic          stream_end;
	} result_t;

	// Picks the header section that follows the finished one.
	function automatic phase_t next_section(input section_t done, input logic [3:0] flags);
		phase_t ph;
		if (done < SEC_EXTRA && flags[FL_EXTRA]) begin
			ph = PH_XLEN0;
		end else if (done < SEC_NAME && flags[FL_NAME]) begin
			ph = PH_NAME;
		end else if (done < SEC_COMMENT && flags[FL_COMMENT]) begin
			ph = PH_COMMENT;
		end else if (done < SEC_HCRC && flags[FL_HCRC]) begin
			ph = PH_HCRC;
		end else begin
			ph = PH_BODY;
		end
		return ph;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/gzhp_fsm.sv */
// Header state machine of the gzip member header parser.
// Updates phase, flags, skip counter and error code once per stepped byte.
// Depends on gzhp_pkg.
`default_nettype none

module gzhp_fsm (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step,
	input  wire  [7:0]          in_byte,
	input  wire                 in_last,
	output gzhp_pkg::result_t   res
);

	gzhp_pkg::phase_t  phase_q, phase_d;
	gzhp_pkg::status_t err_q, err_d;
	logic [3:0]        flags_q, flags_d;
	logic [15:0]       skip_q, skip_d;
	logic [15:0]       skip_dec;
	logic [15:0]       xlen;

	assign skip_dec = skip_q - 16'd1;
	assign xlen     = skip_q | {in_byte, 8'd0};

	always_comb begin
		phase_d = phase_q;
		err_d   = err_q;
		flags_d = flags_q;
		skip_d  = skip_q;
		case (phase_q)
			gzhp_pkg::PH_MAGIC0: begin
				if (in_byte == gzhp_pkg::MAGIC0_BYTE) begin
					phase_d = gzhp_pkg::PH_MAGIC1;
				end else begin
					phase_d = gzhp_pkg::PH_ERROR;
					err_d   = gzhp_pkg::ST_NOT_GZIP;
				end
			end
			gzhp_pkg::PH_MAGIC1: begin
				if (in_byte == gzhp_pkg::MAGIC1_BYTE) begin
					phase_d = gzhp_pkg::PH_METHOD;
				end else begin
					phase_d = gzhp_pkg::PH_ERROR;
					err_d   = gzhp_pkg::ST_NOT_GZIP;
				end
			end
			gzhp_pkg::PH_METHOD: begin
				if (in_byte == gzhp_pkg::METHOD_DEFL) begin
					phase_d = gzhp_pkg::PH_FLAGS;
				end else begin
					phase_d = gzhp_pkg::PH_ERROR;
					err_d   = gzhp_pkg::ST_HDR_ERROR;
				end
			end
			gzhp_pkg::PH_FLAGS: begin
				if ((in_byte & gzhp_pkg::FLG_RESERVED) != 8'd0) begin
					phase_d = gzhp_pkg::PH_ERROR;
					err_d   = gzhp_pkg::ST_HDR_ERROR;
				end else begin
					flags_d = in_byte[4:1];
					skip_d  = gzhp_pkg::FIXED_SKIP;
					phase_d = gzhp_pkg::PH_SKIP;
				end
			end
			gzhp_pkg::PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) begin
					phase_d = gzhp_pkg::next_section(gzhp_pkg::SEC_FIXED, flags_q);
				end
			end
			gzhp_pkg::PH_XLEN0: begin
				skip_d  = {8'd0, in_byte};
				phase_d = gzhp_pkg::PH_XLEN1;
			end
			gzhp_pkg::PH_XLEN1: begin
				skip_d = xlen;
				if (xlen != 16'd0) begin
					phase_d = gzhp_pkg::PH_XDATA;
				end else begin
					phase_d = gzhp_pkg::next_section(gzhp_pkg::SEC_EXTRA, flags_q);
				end
			end
			gzhp_pkg::PH_XDATA: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) begin
					phase_d = gzhp_pkg::next_section(gzhp_pkg::SEC_EXTRA, flags_q);
				end
			end
			gzhp_pkg::PH_NAME: begin
				if (in_byte == 8'd0) begin
					phase_d = gzhp_pkg::next_section(gzhp_pkg::SEC_NAME, flags_q);
				end
			end
			gzhp_pkg::PH_COMMENT: begin
				if (in_byte == 8'd0) begin
					phase_d = gzhp_pkg::next_section(gzhp_pkg::SEC_COMMENT, flags_q);
				end
			end
			gzhp_pkg::PH_HCRC: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) begin
					phase_d = gzhp_pkg::next_section(gzhp_pkg::SEC_HCRC, flags_q);
				end
			end
			gzhp_pkg::PH_BODY: begin
			end
			gzhp_pkg::PH_ERROR: begin
			end
			default: begin
				phase_d = gzhp_pkg::PH_ERROR;
				err_d   = gzhp_pkg::ST_NOT_GZIP;
			end
		endcase
		// Entering the header CRC loads its two-byte count.
		if (phase_d == gzhp_pkg::PH_HCRC && phase_q != gzhp_pkg::PH_HCRC) begin
			skip_d = gzhp_pkg::HCRC_SKIP;
		end
	end

	always_comb begin
		res.payload_valid = (phase_q == gzhp_pkg::PH_BODY);
		res.payload_byte  = (phase_q == gzhp_pkg::PH_BODY) ? in_byte : 8'd0;
		res.stream_end    = in_last;
		if (err_d != gzhp_pkg::ST_PARSING) begin
			res.header_status = err_d;
		end else if (phase_d == gzhp_pkg::PH_BODY) begin
			res.header_status = gzhp_pkg::ST_ACCEPTED;
		end else if (in_last) begin
			if (phase_d == gzhp_pkg::PH_MAGIC0 || phase_d == gzhp_pkg::PH_MAGIC1) begin
				res.header_status = gzhp_pkg::ST_NOT_GZIP;
			end else if (phase_d == gzhp_pkg::PH_METHOD || phase_d == gzhp_pkg::PH_FLAGS) begin
				res.header_status = gzhp_pkg::ST_HDR_ERROR;
			end else begin
				res.header_status = gzhp_pkg::ST_ACCEPTED;
			end
		end else begin
			res.header_status = gzhp_pkg::ST_PARSING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gzhp_pkg::PH_MAGIC0;
			err_q   <= gzhp_pkg::ST_PARSING;
			flags_q <= 4'd0;
			skip_q  <= 16'd0;
		end else if (step) begin
			if (in_last) begin
				phase_q <= gzhp_pkg::PH_MAGIC0;
				err_q   <= gzhp_pkg::ST_PARSING;
				flags_q <= 4'd0;
				skip_q  <= 16'd0;
			end else begin
				phase_q <= phase_d;
				err_q   <= err_d;
				flags_q <= flags_d;
				skip_q  <= skip_d;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/gzip_header_parser.sv */
// Top level of the gzip member header parser: input register, header FSM, result register.
// Depends on gzhp_pkg and gzhp_fsm.
//
//   Port group  Dir  tdata          tuser                             tlast
//   s_axis      in   in_byte[7:0]   -                                 end_of_input
//   m_axis      out  payload_byte   payload_valid, header_status[1:0] stream_end
//
// Each byte passes from the input transaction into the input register, then through the header FSM,
// which updates once per byte, into the result register.
// A new byte is taken every cycle while the output side keeps up.
// Reset clears both stage valids and returns the FSM to the first magic byte.
// A stall on m_axis holds the result and backs up through the input register.
`default_nettype none

module gzip_header_parser (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] payload_byte
	output logic [2:0]  m_axis_tuser,   // [0] payload_valid, [2:1] header_status
	output logic        m_axis_tlast
);

	logic              v_s1, v_s2;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              adv_s1;
	logic              free_s2;
	gzhp_pkg::result_t res;
	gzhp_pkg::result_t res_s2;

	assign free_s2       = !v_s2 || m_axis_tready;
	assign adv_s1        = v_s1 && free_s2;
	assign s_axis_tready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	gzhp_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (free_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = res_s2.payload_byte;
	assign m_axis_tuser  = {res_s2.header_status, res_s2.payload_valid};
	assign m_axis_tlast  = res_s2.stream_end;

	a_payload_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == gzhp_pkg::ST_ACCEPTED)
		else $error("Payload byte delivered without an accepted header.");

	a_no_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
		else $error("Header byte leaked onto the payload data.");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_s1 |=> v_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("Input register lost a byte while the result side stalled.");

endmodule

`default_nettype wire
